// ===== sv/char_lcd_write_sequencer_top_assert.svh =====
// Assertion macros for the character LCD write sequencer.
`ifndef CHAR_LCD_WRITE_SEQUENCER_TOP_ASSERT_SVH
`define CHAR_LCD_WRITE_SEQUENCER_TOP_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, checked at every rising edge out of reset.
`define LCDWS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lcdws assertion failed");
// Next-cycle implication.
`define LCDWS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lcdws assertion failed");
`else
`define LCDWS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define LCDWS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== sv/lcdws_pkg.sv =====
// Types, constants and helper functions shared by the LCD write sequencer.
package lcdws_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned CNT_W       = 20;
   localparam int unsigned CSR_IDX_W   = 3;
   localparam int unsigned CSR_DATA_W  = 20;
   localparam logic [2:0]  INIT_LEN    = 3'd7;
   localparam logic [7:0]  LONG_WAIT_LIMIT = 8'd4;
   localparam logic [4:0]  MAX_COLUMN  = 5'd15;

   // Request kinds on the input channel
   typedef enum logic [2:0] {
      KIND_TICK   = 3'd0,
      KIND_CMD    = 3'd1,
      KIND_DATA   = 3'd2,
      KIND_CURSOR = 3'd3,
      KIND_INIT   = 3'd4
   } kind_type;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PULSE      = 3'd0,
      CSR_SHORT_WAIT = 3'd1,
      CSR_LONG_WAIT  = 3'd2,
      CSR_POWER_ON   = 3'd3,
      CSR_GAP_LONG   = 3'd4,
      CSR_GAP_SHORT  = 3'd5
   } csr_idx_type;

   // Classified operation handed from the front end to the sequencer
   typedef enum logic [2:0] {
      OP_IGNORE   = 3'd0,   // unknown kind: no tick, no rejection
      OP_TICK     = 3'd1,
      OP_WRITE    = 3'd2,
      OP_INIT     = 3'd3,
      OP_BAD_MOVE = 3'd4    // cursor move off the line: rejected if busy only
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] wbyte;
      logic       rs;
   } item_type;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_SETUP = 3'd1,
      PH_PULSE = 3'd2,
      PH_WAIT  = 3'd3,
      PH_GAP   = 3'd4,
      PH_POWER = 3'd5
   } phase_type;

   typedef struct packed {
      logic [7:0]       pulse;
      logic [CNT_W-1:0] short_wait;
      logic [CNT_W-1:0] long_wait;
      logic [CNT_W-1:0] power_on;
      logic [CNT_W-1:0] gap_long;
      logic [CNT_W-1:0] gap_short;
   } cfg_type;

   // DDRAM base address of each display line
   function automatic logic [7:0] row_base(input logic [1:0] row);
      logic [7:0] base;
      case (row)
         2'd0:    base = 8'h80;
         2'd1:    base = 8'hC0;
         2'd2:    base = 8'h90;
         default: base = 8'hD0;
      endcase
      return base;
   endfunction

   // Power-up command list, indexed from zero
   function automatic logic [7:0] init_byte(input logic [2:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0, 3'd1, 3'd2: b = 8'h38;
         3'd3:             b = 8'h08;
         3'd4:             b = 8'h01;
         3'd5:             b = 8'h06;
         default:          b = 8'h0E;
      endcase
      return b;
   endfunction

   // A zero tick count behaves as one tick
   function automatic logic [CNT_W-1:0] at_least_one(input logic [CNT_W-1:0] v);
      return (v == '0) ? CNT_W'(1) : v;
   endfunction

endpackage

// ===== sv/lcdws_front.sv =====
// Front end: decodes a request beat into a classified sequencer operation.
module lcdws_front
   import lcdws_pkg::*;
(
   input  logic [2:0] req_kind,
   input  logic [7:0] req_value,
   input  logic [1:0] req_row,
   input  logic [4:0] req_column,
   output item_type   item
);

   // Classify the kind and build the byte to send
   always_comb begin
      item.op    = OP_IGNORE;
      item.wbyte = req_value;
      item.rs    = 1'b0;
      unique case (req_kind)
         KIND_TICK: begin
            item.op = OP_TICK;
         end
         KIND_CMD: begin
            item.op = OP_WRITE;
         end
         KIND_DATA: begin
            item.op = OP_WRITE;
            item.rs = 1'b1;
         end
         KIND_CURSOR: begin
            item.wbyte = row_base(req_row) + {3'b000, req_column};
            item.op    = (req_column > MAX_COLUMN) ? OP_BAD_MOVE : OP_WRITE;
         end
         KIND_INIT: begin
            item.op = OP_INIT;
         end
         default: begin
            item.op = OP_IGNORE;
         end
      endcase
   end

endmodule

// ===== sv/lcdws_fifo.sv =====
// Short flop-based queue between the decoder and the sequencer.
module lcdws_fifo #(
   parameter int unsigned Width = 8,
   parameter int unsigned Depth = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [Width-1:0] push_data,
   output logic             push_ready,
   input  logic             pop,
   output logic             pop_valid,
   output logic [Width-1:0] pop_data
);

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);

   logic [Width-1:0] mem_ff [Depth];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CntW'(Depth));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      count_in = count_ff + CntW'(do_push) - CntW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/lcdws_back.sv =====
// Back end: phase sequencer, timing counter and registered result beat.
module lcdws_back
   import lcdws_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     q_valid,
   input  item_type q_item,
   output logic     q_pop,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output logic     rsp_rs_pin,
   output logic     rsp_enable_pin,
   output logic [7:0] rsp_bus_byte,
   output logic     rsp_busy_res,
   output logic     rsp_rejected
);

   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] cd_ff, cd_in, cd_dec;
   logic [7:0]       byte_ff, byte_in;
   logic             rs_ff, rs_in;
   logic [2:0]       step_ff, step_in;
   logic             rej;
   logic             cd_zero;
   logic             advance;
   logic [CNT_W-1:0] gap;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_rs_ff, rsp_en_ff, rsp_busy_ff, rsp_rej_ff;
   logic [7:0]       rsp_byte_ff;

   // Take an item whenever the result register is free or being drained
   assign q_pop = q_valid && (!rsp_valid_ff || rsp_ready);

   assign cd_dec  = cd_ff - CNT_W'(cd_ff != '0);
   assign cd_zero = (cd_dec == '0);

   // Next phase, counter and latched bus values
   always_comb begin
      phase_in = phase_ff;
      cd_in    = cd_ff;
      byte_in  = byte_ff;
      rs_in    = rs_ff;
      step_in  = step_ff;
      rej      = 1'b0;
      advance  = 1'b0;
      gap      = '0;

      if (q_pop) begin
         if (q_item.op == OP_TICK) begin
            unique case (phase_ff)
               PH_IDLE: begin
                  phase_in = PH_IDLE;
               end
               PH_SETUP: begin
                  phase_in = PH_PULSE;
                  cd_in    = at_least_one({{(CNT_W-8){1'b0}}, cfg.pulse});
               end
               PH_PULSE: begin
                  cd_in = cd_dec;
                  if (cd_zero) begin
                     phase_in = PH_WAIT;
                     if (!rs_ff && (byte_ff < LONG_WAIT_LIMIT)) begin
                        cd_in = at_least_one(cfg.long_wait);
                     end else begin
                        cd_in = at_least_one(cfg.short_wait);
                     end
                  end
               end
               PH_WAIT: begin
                  cd_in = cd_dec;
                  if (cd_zero) begin
                     if (step_ff == 3'd0) begin
                        phase_in = PH_IDLE;
                        cd_in    = '0;
                     end else begin
                        if (step_ff == 3'd1) begin
                           gap = cfg.gap_long;
                        end else if (step_ff == 3'd2) begin
                           gap = cfg.gap_short;
                        end
                        if (gap != '0) begin
                           phase_in = PH_GAP;
                           cd_in    = gap;
                        end else begin
                           advance = 1'b1;
                        end
                     end
                  end
               end
               PH_GAP: begin
                  cd_in = cd_dec;
                  if (cd_zero) begin
                     advance = 1'b1;
                  end
               end
               PH_POWER: begin
                  cd_in = cd_dec;
                  if (cd_zero) begin
                     step_in  = 3'd1;
                     byte_in  = init_byte(3'd0);
                     rs_in    = 1'b0;
                     phase_in = PH_SETUP;
                     cd_in    = '0;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
                  cd_in    = '0;
               end
            endcase
         end else if (q_item.op != OP_IGNORE) begin
            if (phase_ff != PH_IDLE) begin
               rej = 1'b1;
            end else if (q_item.op == OP_WRITE) begin
               byte_in  = q_item.wbyte;
               rs_in    = q_item.rs;
               phase_in = PH_SETUP;
               cd_in    = '0;
            end else if (q_item.op == OP_INIT) begin
               step_in  = 3'd1;
               phase_in = PH_POWER;
               cd_in    = at_least_one(cfg.power_on);
            end
         end
      end

      // Step to the next power-up command or finish the sequence
      if (advance) begin
         if ((step_ff >= INIT_LEN) || (step_ff == 3'd0)) begin
            step_in  = 3'd0;
            phase_in = PH_IDLE;
            cd_in    = '0;
         end else begin
            step_in  = step_ff + 3'd1;
            byte_in  = init_byte(step_ff);
            rs_in    = 1'b0;
            phase_in = PH_SETUP;
            cd_in    = '0;
         end
      end
   end

   assign rsp_valid_in = q_pop || (rsp_valid_ff && !rsp_ready);

   // Sequencer state register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         cd_ff        <= '0;
         byte_ff      <= '0;
         rs_ff        <= 1'b0;
         step_ff      <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         cd_ff        <= cd_in;
         byte_ff      <= byte_in;
         rs_ff        <= rs_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result beat payload
   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_rs_ff   <= rs_in;
         rsp_en_ff   <= (phase_in == PH_PULSE);
         rsp_byte_ff <= byte_in;
         rsp_busy_ff <= (phase_in != PH_IDLE);
         rsp_rej_ff  <= rej;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_rs_pin     = rsp_rs_ff;
   assign rsp_enable_pin = rsp_en_ff;
   assign rsp_bus_byte   = rsp_byte_ff;
   assign rsp_busy_res   = rsp_busy_ff;
   assign rsp_rejected   = rsp_rej_ff;

endmodule

// ===== sv/char_lcd_write_sequencer_top.sv =====
// Top level of the character LCD write sequencer: config registers and wiring.
//
// Takes one request beat per clock while req_ready is high and returns exactly one
// result beat for each, carrying the bus pins after that item. A beat is decoded on
// entry and parked in a QueueDepth-entry queue; the sequencer takes one beat a
// cycle from it if rsp has room and registers its result, which appears on rsp in
// the cycle after the beat leaves the queue. Sustained rate is one item per clock
// whenever rsp_ready stays high; with rsp stalled, up to QueueDepth further beats
// are still accepted. Time is counted in tick items, not clocks. Configuration
// writes must be done while the block is idle. No clearing pass after reset.
module char_lcd_write_sequencer_top
   import lcdws_pkg::*;
#(
   parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [2:0]            req_kind,
   input  logic [7:0]            req_value,
   input  logic [1:0]            req_row,
   input  logic [4:0]            req_column,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_rs_pin,
   output logic                  rsp_rw_pin,
   output logic                  rsp_enable_pin,
   output logic [7:0]            rsp_bus_byte,
   output logic                  rsp_busy_res,
   output logic                  rsp_rejected,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

`include "char_lcd_write_sequencer_top_assert.svh"

   localparam int unsigned ItemW = $bits(item_type);

   cfg_type  cfg_ff, cfg_in;
   item_type dec_item, q_item;
   logic     q_valid, q_pop;

   // Configuration registers, one write per beat
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PULSE:      cfg_in.pulse      = csr_wdata[7:0];
            CSR_SHORT_WAIT: cfg_in.short_wait = csr_wdata;
            CSR_LONG_WAIT:  cfg_in.long_wait  = csr_wdata;
            CSR_POWER_ON:   cfg_in.power_on   = csr_wdata;
            CSR_GAP_LONG:   cfg_in.gap_long   = csr_wdata;
            CSR_GAP_SHORT:  cfg_in.gap_short  = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulse      <= 8'd1;
         cfg_ff.short_wait <= CNT_W'(40);
         cfg_ff.long_wait  <= CNT_W'(2000);
         cfg_ff.power_on   <= CNT_W'(20000);
         cfg_ff.gap_long   <= CNT_W'(5000);
         cfg_ff.gap_short  <= CNT_W'(100);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Decode, queue, sequence
   lcdws_front u_front (
      .req_kind   (req_kind),
      .req_value  (req_value),
      .req_row    (req_row),
      .req_column (req_column),
      .item       (dec_item)
   );

   lcdws_fifo #(
      .Width (ItemW),
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_valid),
      .push_data  (dec_item),
      .push_ready (req_ready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_data   (q_item)
   );

   lcdws_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_rs_pin     (rsp_rs_pin),
      .rsp_enable_pin (rsp_enable_pin),
      .rsp_bus_byte   (rsp_bus_byte),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_rejected   (rsp_rejected)
   );

   assign rsp_rw_pin = 1'b0;

   // Checks
   `LCDWS_ASSERT_IMPL(a_enable_means_busy, clock, reset, rsp_valid && rsp_enable_pin, rsp_busy_res)
   `LCDWS_ASSERT_NEXT(a_accept_fills_queue, clock, reset, req_valid && req_ready, q_valid)
   `LCDWS_ASSERT_IMPL(a_pop_has_room, clock, reset, q_pop, q_valid && (!rsp_valid || rsp_ready))
   `LCDWS_ASSERT_NEXT(a_pop_gives_result, clock, reset, q_pop, rsp_valid)

endmodule
